>>> design/crbck_pkg.sv
package crbck_pkg;

  localparam int unsigned MAX_DEST_DIM_DEF = 2048;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  localparam logic [12:0] SRC_W_RST = 13'd640;
  localparam logic [12:0] SRC_H_RST = 13'd480;
  localparam logic [11:0] DST_W_RST = 12'd320;
  localparam logic [11:0] DST_H_RST = 12'd240;

  // With this source width the colour key is forced off in normal mode.
  localparam logic [12:0] KEY_OFF_WIDTH = 13'd640;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [12:0] rect_w;
    logic [12:0] rect_h;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic        key_request;
    logic [7:0]  source_pixel;
  } crbck_in_t;

  typedef struct packed {
    logic        read_valid;
    logic [23:0] read_address;
    logic        write_enable;
    logic [21:0] write_address;
    logic [7:0]  write_pixel;
    logic        done_res;
  } crbck_out_t;

endpackage

>>> design/crbck_stream_if.sv
interface crbck_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/clipped_rect_blit_color_key.sv
// Rectangle blitter for 8-bit palette pixels with colour key and 2:1 decimation.
// Configuration: an APB-style port holds source and destination sizes. The user
// must write it only while no blit is in flight; the block itself does not
// enforce this. pready is always high. Input channel in_i: a start item latches
// the rectangle, destination origin and key request, clips the region and yields
// one result asking for the first source pixel, or one with done_res set if the
// clipped region is empty. Each pixel item carries the requested pixel and
// yields one result with the destination write and the next read request; the
// last one has done_res set. A pixel item while no blit runs yields an all-zero
// result. Output channel out_o: exactly one result item per accepted input item.
// Throughput is one item per clock while out_o does not stall. Clipping and the
// counter update happen in the cycle an item is accepted, the two address
// multipliers work in the next cycle, and the result is offered from the output
// register. When out_o stalls, results hold in the output register and the
// middle stage still fills, so in_i stays ready until both are occupied.
// Reset clears the pipeline and blit state and loads the default sizes.
module clipped_rect_blit_color_key #(
  parameter int unsigned MAX_DEST_DIM = crbck_pkg::MAX_DEST_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crbck_pkg::APB_AW-1:0]    paddr,
  input  logic [crbck_pkg::APB_DW-1:0]    pwdata,
  output logic [crbck_pkg::APB_DW-1:0]    prdata,
  output logic                            pready,
  crbck_stream_if.sink                    in_i,
  crbck_stream_if.source                  out_o
);
  import crbck_pkg::*;

  typedef struct packed {
    logic        rv;
    logic [13:0] rd_col;
    logic [13:0] rd_row;
    logic [12:0] sw;
    logic        we;
    logic [12:0] wr_col;
    logic [12:0] wr_row;
    logic [11:0] dw;
    logic [7:0]  pix;
    logic        done;
  } s1_t;

  localparam logic [12:0] MaxDim = 13'(MAX_DEST_DIM);

  function automatic logic [12:0] clip_span(logic [12:0] len, logic [12:0] start,
                                            logic [12:0] limit);
    logic [12:0] room;
    room = (start >= limit) ? 13'd0 : limit - start;
    return (len < room) ? len : room;
  endfunction

  logic [12:0] src_w_q, src_h_q;
  logic [11:0] dst_w_q, dst_h_q;

  logic        busy_q, busy_d;
  logic        dec_q, dec_d;
  logic        key_q, key_d;
  logic [11:0] col_q, col_d, row_q, row_d;
  logic [11:0] reg_w_q, reg_w_d, reg_h_q, reg_h_d;
  logic [11:0] soc_q, soc_d, sor_q, sor_d;
  logic [10:0] doc_q, doc_d, dor_q, dor_d;

  logic        s1_vld_q, s2_vld_q;
  s1_t         s1_q, s1_d;
  crbck_out_t  s2_q;

  logic        s2_load, s1_load, in_fire;
  crbck_in_t   in;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_W_RST;
      src_h_q <= SRC_H_RST;
      dst_w_q <= DST_W_RST;
      dst_h_q <= DST_H_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SRC_W: src_w_q <= pwdata[12:0];
        REG_SRC_H: src_h_q <= pwdata[12:0];
        REG_DST_W: dst_w_q <= pwdata[11:0];
        REG_DST_H: dst_h_q <= pwdata[11:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_W: prdata = APB_DW'(src_w_q);
      REG_SRC_H: prdata = APB_DW'(src_h_q);
      REG_DST_W: prdata = APB_DW'(dst_w_q);
      REG_DST_H: prdata = APB_DW'(dst_h_q);
      default:   prdata = '0;
    endcase
  end

  // Pipeline handshake
  assign s2_load  = !s2_vld_q || out_o.ready;
  assign s1_load  = !s1_vld_q || s2_load;
  assign in_i.ready = s1_load;
  assign in_fire  = in_i.valid && in_i.ready;
  assign in       = in_i.data;

  // Stage one: clipping and counter update
  logic        dec_c, oversize, last_c, wrap_c;
  logic [12:0] w_c, h_c;
  logic [11:0] col_n, row_n;

  always_comb begin
    dec_c    = (src_w_q == {dst_w_q, 1'b0}) && (src_h_q == {dst_h_q, 1'b0});
    oversize = ({1'b0, dst_w_q} > MaxDim) || ({1'b0, dst_h_q} > MaxDim);
    if (dec_c) begin
      w_c = clip_span(clip_span({1'b0, dst_w_q}, {2'b0, in.rect_x[11:1]}, {1'b0, dst_w_q}),
                      {2'b0, in.dest_x}, {1'b0, dst_w_q});
      h_c = clip_span(clip_span({1'b0, dst_h_q}, {2'b0, in.rect_y[11:1]}, {1'b0, dst_h_q}),
                      {2'b0, in.dest_y}, {1'b0, dst_h_q});
    end else begin
      w_c = clip_span(clip_span(in.rect_w, {1'b0, in.rect_x}, src_w_q),
                      {2'b0, in.dest_x}, {1'b0, dst_w_q});
      h_c = clip_span(clip_span(in.rect_h, {1'b0, in.rect_y}, src_h_q),
                      {2'b0, in.dest_y}, {1'b0, dst_h_q});
    end
    if (oversize) begin
      w_c = '0;
      h_c = '0;
    end

    col_n  = col_q + 12'd1;
    wrap_c = (col_n >= reg_w_q);
    row_n  = wrap_c ? row_q + 12'd1 : row_q;
    col_n  = wrap_c ? 12'd0 : col_n;
    last_c = (row_n >= reg_h_q);

    busy_d = busy_q;
    dec_d  = dec_q;
    key_d  = key_q;
    col_d  = col_q;
    row_d  = row_q;
    reg_w_d = reg_w_q;
    reg_h_d = reg_h_q;
    soc_d  = soc_q;
    sor_d  = sor_q;
    doc_d  = doc_q;
    dor_d  = dor_q;

    s1_d        = '0;
    s1_d.sw     = src_w_q;
    s1_d.dw     = dst_w_q;
    s1_d.wr_col = 13'(doc_q) + 13'(col_q);
    s1_d.wr_row = 13'(dor_q) + 13'(row_q);
    s1_d.pix    = in.source_pixel;

    if (in.kind == KIND_START) begin
      dec_d   = dec_c;
      key_d   = in.key_request && (dec_c || (src_w_q != KEY_OFF_WIDTH));
      reg_w_d = w_c[11:0];
      reg_h_d = h_c[11:0];
      if (!oversize) begin
        soc_d = dec_c ? {in.rect_x[11:1], 1'b0} : in.rect_x;
        sor_d = dec_c ? {in.rect_y[11:1], 1'b0} : in.rect_y;
      end
      doc_d  = in.dest_x;
      dor_d  = in.dest_y;
      col_d  = '0;
      row_d  = '0;
      busy_d = (w_c[11:0] != 12'd0) && (h_c[11:0] != 12'd0);
      s1_d.rv     = busy_d;
      s1_d.rd_col = 14'(soc_d);
      s1_d.rd_row = 14'(sor_d);
      s1_d.done   = !busy_d;
    end else if (busy_q) begin
      s1_d.we = !(key_q && (in.source_pixel == 8'd0));
      if (last_c) begin
        busy_d    = 1'b0;
        col_d     = '0;
        row_d     = '0;
        s1_d.done = 1'b1;
      end else begin
        col_d       = col_n;
        row_d       = row_n;
        s1_d.rv     = 1'b1;
        s1_d.rd_col = 14'(soc_q) + (dec_q ? {1'b0, col_n, 1'b0} : 14'(col_n));
        s1_d.rd_row = 14'(sor_q) + (dec_q ? {1'b0, row_n, 1'b0} : 14'(row_n));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      dec_q   <= 1'b0;
      key_q   <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      reg_w_q <= '0;
      reg_h_q <= '0;
      soc_q   <= '0;
      sor_q   <= '0;
      doc_q   <= '0;
      dor_q   <= '0;
    end else if (in_fire) begin
      busy_q  <= busy_d;
      dec_q   <= dec_d;
      key_q   <= key_d;
      col_q   <= col_d;
      row_q   <= row_d;
      reg_w_q <= reg_w_d;
      reg_h_q <= reg_h_d;
      soc_q   <= soc_d;
      sor_q   <= sor_d;
      doc_q   <= doc_d;
      dor_q   <= dor_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_load) begin
      s1_vld_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // Stage two: linear address multipliers
  logic [26:0] rd_prod;
  logic [24:0] wr_prod;
  crbck_out_t  s2_d;

  always_comb begin
    rd_prod = 27'(s1_q.rd_row) * 27'(s1_q.sw);
    wr_prod = 25'(s1_q.wr_row) * 25'(s1_q.dw);
    s2_d.read_valid    = s1_q.rv;
    s2_d.read_address  = s1_q.rv ? 24'(s1_q.rd_col) + rd_prod[23:0] : 24'd0;
    s2_d.write_enable  = s1_q.we;
    s2_d.write_address = s1_q.we ? 22'(s1_q.wr_col) + wr_prod[21:0] : 22'd0;
    s2_d.write_pixel   = s1_q.we ? s1_q.pix : 8'd0;
    s2_d.done_res      = s1_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_load) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_vld_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_o.valid = s2_vld_q;
  assign out_o.data  = s2_q;

endmodule

>>> sim/tb_clipped_rect_blit_color_key.sv
`timescale 1ns / 1ps

module tb_clipped_rect_blit_color_key;
  import crbck_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  crbck_stream_if #(.T(crbck_in_t)) in_if ();
  crbck_stream_if #(.T(crbck_out_t)) out_if ();

  clipped_rect_blit_color_key dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Surface sizes as the block should currently hold them.
  logic [12:0] cfg_src_w = SRC_W_RST;
  logic [12:0] cfg_src_h = SRC_H_RST;
  logic [11:0] cfg_dst_w = DST_W_RST;
  logic [11:0] cfg_dst_h = DST_H_RST;

  // Blit state tracked alongside the block.
  bit bl_busy = 1'b0;
  bit bl_decimate = 1'b0;
  bit bl_keying = 1'b0;
  int unsigned bl_col = 0;
  int unsigned bl_row = 0;
  int unsigned bl_w = 0;
  int unsigned bl_h = 0;
  int unsigned bl_src_col = 0;
  int unsigned bl_src_row = 0;
  int unsigned bl_dst_col = 0;
  int unsigned bl_dst_row = 0;

  crbck_out_t pending_blit_results[$];
  int unsigned blit_mismatches = 0;
  int unsigned blit_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit long_hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clip_len(int unsigned len, int unsigned start,
                                           int unsigned lim);
    int unsigned room;
    room = (start >= lim) ? 0 : lim - start;
    return (len < room) ? len : room;
  endfunction

  function automatic logic [23:0] source_addr();
    int unsigned stride;
    int unsigned c;
    int unsigned r;
    stride = bl_decimate ? 2 : 1;
    c = bl_src_col + stride * bl_col;
    r = bl_src_row + stride * bl_row;
    return 24'(c + r * 32'(cfg_src_w));
  endfunction

  function automatic crbck_out_t next_blit_result(input crbck_in_t it);
    crbck_out_t res;
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned w;
    int unsigned h;
    bit dec;
    bit we;
    res = '0;
    sw = 32'(cfg_src_w);
    sh = 32'(cfg_src_h);
    dw = 32'(cfg_dst_w);
    dh = 32'(cfg_dst_h);
    if (it.kind == KIND_START) begin
      dec = (sw == 2 * dw) && (sh == 2 * dh);
      bl_busy = 1'b0;
      if (dw > MAX_DEST_DIM_DEF || dh > MAX_DEST_DIM_DEF) begin
        w = 0;
        h = 0;
      end else if (dec) begin
        w = clip_len(clip_len(dw, 32'(it.rect_x >> 1), dw), 32'(it.dest_x), dw);
        h = clip_len(clip_len(dh, 32'(it.rect_y >> 1), dh), 32'(it.dest_y), dh);
        bl_src_col = 32'(it.rect_x >> 1) << 1;
        bl_src_row = 32'(it.rect_y >> 1) << 1;
      end else begin
        w = clip_len(clip_len(32'(it.rect_w), 32'(it.rect_x), sw), 32'(it.dest_x), dw);
        h = clip_len(clip_len(32'(it.rect_h), 32'(it.rect_y), sh), 32'(it.dest_y), dh);
        bl_src_col = 32'(it.rect_x);
        bl_src_row = 32'(it.rect_y);
      end
      bl_decimate = dec;
      bl_keying = dec ? it.key_request : (it.key_request && sw != KEY_OFF_WIDTH);
      bl_w = w & 32'hFFF;
      bl_h = h & 32'hFFF;
      bl_dst_col = 32'(it.dest_x);
      bl_dst_row = 32'(it.dest_y);
      bl_col = 0;
      bl_row = 0;
      if (bl_w == 0 || bl_h == 0) begin
        res.done_res = 1'b1;
      end else begin
        bl_busy = 1'b1;
        res.read_valid = 1'b1;
        res.read_address = source_addr();
      end
    end else if (bl_busy) begin
      we = !(bl_keying && it.source_pixel == 8'd0);
      res.write_enable = we;
      if (we) begin
        res.write_address = 22'((bl_dst_col + bl_col) + (bl_dst_row + bl_row) * dw);
        res.write_pixel = it.source_pixel;
      end
      bl_col++;
      if (bl_col >= bl_w) begin
        bl_col = 0;
        bl_row++;
      end
      if (bl_row >= bl_h) begin
        bl_busy = 1'b0;
        bl_col = 0;
        bl_row = 0;
        res.done_res = 1'b1;
      end else begin
        res.read_valid = 1'b1;
        res.read_address = source_addr();
      end
    end
    return res;
  endfunction

  function automatic crbck_in_t make_start(int unsigned rx, int unsigned ry,
                                           int unsigned rw, int unsigned rh,
                                           int unsigned dx, int unsigned dy, bit key);
    crbck_in_t it;
    it.kind = KIND_START;
    it.rect_x = 12'(rx);
    it.rect_y = 12'(ry);
    it.rect_w = 13'(rw);
    it.rect_h = 13'(rh);
    it.dest_x = 11'(dx);
    it.dest_y = 11'(dy);
    it.key_request = key;
    it.source_pixel = 8'($urandom);
    return it;
  endfunction

  function automatic crbck_in_t make_pixel(logic [7:0] pix);
    crbck_in_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(crbck_in_t)-1:0];
    it.kind = KIND_PIXEL;
    it.source_pixel = pix;
    return it;
  endfunction

  function automatic int unsigned pick_coord(int unsigned limit, int unsigned maxv);
    int unsigned v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, maxv);
      1: v = $urandom_range(0, 7);
      default: v = (limit > 8) ? limit - $urandom_range(1, 8) : $urandom_range(0, limit);
    endcase
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 4096);
  endfunction

  task automatic send_item(input crbck_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    if (it.kind == KIND_START || bl_busy) blit_items++;
    pending_blit_results.push_back(next_blit_result(it));
  endtask

  task automatic send_pixel_run(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(make_pixel((i % 2 == 0) ? 8'h00 : 8'($urandom_range(1, 255))));
    end
  endtask

  task automatic wait_blitter_idle();
    in_if.valid <= 1'b0;
    while (pending_blit_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_W: cfg_src_w = val[12:0];
      REG_SRC_H: cfg_src_h = val[12:0];
      REG_DST_W: cfg_dst_w = val[11:0];
      REG_DST_H: cfg_dst_h = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_surfaces(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh);
    wait_blitter_idle();
    apb_write(REG_SRC_W, sw);
    apb_write(REG_SRC_H, sh);
    apb_write(REG_DST_W, dw);
    apb_write(REG_DST_H, dh);
  endtask

  task automatic random_surfaces();
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    sw = $urandom_range(1, 40);
    sh = $urandom_range(1, 40);
    dw = $urandom_range(1, 40);
    dh = $urandom_range(1, 40);
    case ($urandom_range(0, 9))
      4, 5: begin
        dw = $urandom_range(1, 12);
        dh = $urandom_range(1, 12);
        sw = 2 * dw;
        sh = 2 * dh;
      end
      6: begin
        sw = 32'(KEY_OFF_WIDTH);
        sh = $urandom_range(1, 480);
        dw = $urandom_range(1, 2048);
        dh = $urandom_range(1, 2048);
      end
      7: begin
        sw = $urandom_range(0, 1) ? 4096 : 1;
        sh = $urandom_range(0, 1) ? 4096 : 1;
        dw = $urandom_range(0, 1) ? 2048 : 1;
        dh = $urandom_range(0, 1) ? 2048 : 1;
      end
      8: begin
        dw = $urandom_range(0, 1) ? 2048 : $urandom_range(1, 2048);
        dh = $urandom_range(1, 2048);
        sw = 2 * dw;
        sh = 2 * dh;
      end
      9: begin
        dw = $urandom_range(0, 1) ? $urandom_range(2049, 4095) : dw;
        dh = $urandom_range(2049, 4095);
      end
      default: ;
    endcase
    set_surfaces(sw, sh, dw, dh);
  endtask

  // A start followed by the pixels it asks for; some blits are cut short by the
  // next start, and a stray pixel sometimes follows a finished one.
  task automatic random_blit();
    int unsigned cap;
    int unsigned sent;
    send_item(make_start(pick_coord(32'(cfg_src_w), 4095), pick_coord(32'(cfg_src_h), 4095),
                         pick_len(), pick_len(), pick_coord(32'(cfg_dst_w), 2047),
                         pick_coord(32'(cfg_dst_h), 2047), 1'($urandom_range(0, 1))));
    cap = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 5) : 64;
    sent = 0;
    while (bl_busy && sent < cap) begin
      send_item(make_pixel(($urandom_range(0, 99) < 30) ? 8'h00 : 8'($urandom)));
      sent++;
    end
    if (!bl_busy && $urandom_range(0, 99) < 10) send_item(make_pixel(8'($urandom)));
  endtask

  task automatic note_mismatch(input string what, input crbck_out_t want,
                               input crbck_out_t got);
    blit_mismatches++;
    if (blit_mismatches <= 10) begin
      $display("%0t %s: expected rv=%0b ra=%h we=%0b wa=%h px=%h done=%0b", $realtime,
               what, want.read_valid, want.read_address, want.write_enable,
               want.write_address, want.write_pixel, want.done_res);
      $display("      got rv=%0b ra=%h we=%0b wa=%h px=%h done=%0b", got.read_valid,
               got.read_address, got.write_enable, got.write_address, got.write_pixel,
               got.done_res);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    crbck_out_t want;
    crbck_out_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_blit_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_blit_results.pop_front();
        if (want.read_valid !== got.read_valid ||
            want.read_address !== got.read_address ||
            want.write_enable !== got.write_enable ||
            want.write_address !== got.write_address ||
            want.write_pixel !== got.write_pixel ||
            want.done_res !== got.done_res) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_clipped_rect_blit_color_key failed");
      $finish;
    end
  end

  // The reset sizes select decimation mode, so keying follows the request.
  task automatic test_reset_defaults();
    send_item(make_pixel(8'hFF));
    send_item(make_start(634, 476, 4096, 4096, 316, 237, 1'b1));
    send_item(make_pixel(8'hFF));
    send_pixel_run(5);
  endtask

  task automatic test_clipping_extremes();
    set_surfaces(4096, 4095, 2048, 2048);
    send_item(make_start(4095, 4095, 4096, 4096, 0, 0, 1'b1));
    send_item(make_start(4094, 4093, 4096, 4096, 2047, 2046, 1'b1));
    send_item(make_pixel(8'h00));
    send_item(make_pixel(8'hFF));
    send_item(make_start(0, 0, 0, 5, 0, 0, 1'b0));
    send_item(make_start(0, 0, 3, 3, 2047, 2047, 1'b0));
    send_item(make_pixel(8'h00));
    send_item(make_start(1, 2, 4, 4, 10, 20, 1'b0));
    send_pixel_run(2);
    send_item(make_start(0, 0, 2, 1, 0, 0, 1'b1));
    send_pixel_run(2);
  endtask

  task automatic test_key_off_width();
    set_surfaces(32'(KEY_OFF_WIDTH), 100, 320, 99);
    send_item(make_start(5, 5, 2, 1, 3, 3, 1'b1));
    send_item(make_pixel(8'h00));
    send_item(make_pixel(8'h00));
  endtask

  task automatic test_oversized_dest();
    set_surfaces(100, 100, 2049, 10);
    send_item(make_start(0, 0, 4, 4, 0, 0, 1'b0));
    set_surfaces(100, 100, 10, 4095);
    send_item(make_start(0, 0, 4, 4, 0, 0, 1'b0));
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_surfaces(32, 32, 32, 32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    send_item(make_start(0, 0, 8, 4, 4, 4, 1'b1));
    send_pixel_run(32);
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned quota);
    int unsigned target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = blit_items + quota;
    while (blit_items < target) begin
      random_surfaces();
      repeat ($urandom_range(3, 8)) random_blit();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_clipping_extremes();
    test_key_off_width();
    test_oversized_dest();
    test_backpressure();
    test_random_traffic(0, 0, 240);
    test_random_traffic(51, 0, 240);
    test_random_traffic(0, 51, 240);
    test_random_traffic(19, 19, 240);
    wait_blitter_idle();
    repeat (8) @(posedge clk_i);
    if (blit_mismatches == 0 && pending_blit_results.size() == 0) begin
      $display("tb_clipped_rect_blit_color_key passed");
    end else begin
      $display("tb_clipped_rect_blit_color_key failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/crbck_pkg.sv
design/crbck_stream_if.sv
design/clipped_rect_blit_color_key.sv
sim/tb_clipped_rect_blit_color_key.sv
